// File: hdl/sbpr_pkg.sv
package sbpr_pkg;

  localparam int NumSamples = 5;
  localparam int SampleW    = 6;

  typedef logic [SampleW-1:0] sample_t;
  typedef sample_t [NumSamples-1:0] sample_arr_t;

  localparam logic [1:0] OP_POLL   = 2'd1;
  localparam logic [1:0] OP_DETECT = 2'd2;

  localparam logic [1:0] KIND_ONE   = 2'd0;
  localparam logic [1:0] KIND_TWO   = 2'd1;
  localparam logic [1:0] KIND_THREE = 2'd2;
  localparam logic [1:0] KIND_SIX   = 2'd3;

  localparam int SMP_A = 0;
  localparam int SMP_B = 1;
  localparam int SMP_C = 2;
  localparam int SMP_D = 3;
  localparam int SMP_E = 4;

  localparam logic [2:0] HP_A    = 3'd0;
  localparam logic [2:0] HP_B    = 3'd1;
  localparam logic [2:0] HP_D    = 3'd3;
  localparam logic [2:0] HP_E    = 3'd5;
  localparam logic [2:0] HP_C    = 3'd6;
  localparam logic [2:0] HP_LAST = 3'd7;

  localparam logic [3:0] NIB_MULTITAP  = 4'h3;
  localparam logic [3:0] NIB_IDLE      = 4'hf;
  localparam sample_t    PINS_RELEASED = 6'h3f;

  localparam logic [7:0] AXIS_MIN = 8'd0;
  localparam logic [7:0] AXIS_MID = 8'h80;
  localparam logic [7:0] AXIS_MAX = 8'hff;

  localparam logic [15:0] PHASE_TICKS_RST = 16'd20;

  typedef struct packed {
    logic [3:0]  step;
    logic [15:0] tick;
    logic [1:0]  kind;
    logic [23:0] prev;
    logic        first;
    logic        det;
    logic        mt;
  } ctl_t;

  typedef struct packed {
    logic       sel;
    logic       busy;
    logic       valid;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] btn;
    logic       changed;
    logic [1:0] kind;
    logic       mt;
  } res_t;

endpackage

// File: hdl/sbpr_step.sv
module sbpr_step (
  input  sbpr_pkg::ctl_t        ctl,
  input  sbpr_pkg::sample_arr_t smp,
  input  logic [15:0]           phase_ticks,
  input  logic [1:0]            operation,
  input  logic [5:0]            pad_pins,
  output sbpr_pkg::ctl_t        ctl_nxt,
  output sbpr_pkg::sample_arr_t smp_nxt,
  output sbpr_pkg::res_t        res
);
  import sbpr_pkg::*;

  logic        start;
  logic [3:0]  step_e;
  logic [15:0] tick_e;
  logic        det_e;
  logic [2:0]  h;
  logic [15:0] limit;
  logic        done;
  logic        single;
  logic        last;
  sample_t     d0;
  sample_t     d1;
  sample_t     d2;
  logic [7:0]  rx;
  logic [7:0]  ry;
  logic [7:0]  rbtn;
  logic [23:0] rep;
  logic [1:0]  cls_kind;
  logic        cls_mt;

  assign start  = (ctl.step == '0) && (operation == OP_POLL || operation == OP_DETECT);
  assign step_e = start ? 4'd1 : ctl.step;
  assign tick_e = start ? '0 : ctl.tick;
  assign det_e  = start ? (operation == OP_DETECT) : ctl.det;
  assign h      = 3'(step_e - 4'd1);
  assign limit  = (phase_ticks == '0) ? 16'd1 : phase_ticks;
  assign done   = ({1'b0, tick_e} + 17'd1) >= {1'b0, limit};
  assign single = !det_e && (ctl.kind == KIND_ONE || ctl.kind == KIND_TWO);
  assign last   = (single && h == HP_A) || h == HP_LAST;

  // classify from the stored samples
  always_comb begin
    cls_kind = KIND_TWO;
    cls_mt   = 1'b0;
    if (smp[SMP_A][3:0] == NIB_MULTITAP) begin
      cls_mt = 1'b1;
    end else begin
      if (smp[SMP_A][3:0] == NIB_IDLE && smp[SMP_B][3:0] == NIB_MULTITAP) begin
        if (smp[SMP_D][3:0] != NIB_MULTITAP || smp[SMP_E][3:0] != NIB_MULTITAP) begin
          cls_kind = KIND_SIX;
        end else begin
          cls_kind = KIND_THREE;
        end
      end
      if (!smp[SMP_B][5]) begin
        cls_kind = KIND_SIX;
      end
    end
  end

  // build report, with the single-phase sample substitution
  always_comb begin
    d0   = ~(single ? pad_pins : smp[SMP_A]);
    d1   = ~(single ? PINS_RELEASED : smp[SMP_B]);
    d2   = ~(single ? PINS_RELEASED : smp[SMP_C]);
    rx   = AXIS_MID;
    ry   = AXIS_MID;
    rbtn = '0;
    if (d0[0]) ry = AXIS_MIN;
    if (d0[1]) ry = AXIS_MAX;
    if (d0[2]) rx = AXIS_MIN;
    if (d0[3]) rx = AXIS_MAX;
    if (ctl.kind == KIND_THREE || ctl.kind == KIND_SIX) begin
      rbtn[0] = d1[4];
      rbtn[1] = d0[4];
      rbtn[2] = d0[5];
      rbtn[3] = d1[5];
      if (ctl.kind == KIND_SIX) begin
        rbtn[4] = d2[2];
        rbtn[5] = d2[1];
        rbtn[6] = d2[0];
        rbtn[7] = d2[3];
      end
    end else begin
      rbtn[0] = d0[4];
      rbtn[1] = d0[5];
    end
    rep = {rbtn, ry, rx};
  end

  always_comb begin
    ctl_nxt      = ctl;
    ctl_nxt.step = step_e;
    ctl_nxt.tick = tick_e;
    ctl_nxt.det  = det_e;
    smp_nxt      = smp;
    res          = '0;
    res.sel      = 1'b1;
    if (step_e != '0) begin
      res.busy = 1'b1;
      res.sel  = !h[0];
      if (done) begin
        case (h)
          HP_A:    smp_nxt[SMP_A] = pad_pins;
          HP_B:    smp_nxt[SMP_B] = pad_pins;
          HP_D:    smp_nxt[SMP_D] = pad_pins;
          HP_E:    smp_nxt[SMP_E] = pad_pins;
          HP_C:    smp_nxt[SMP_C] = pad_pins;
          default: ;
        endcase
        ctl_nxt.tick = '0;
        if (last) begin
          if (single) begin
            smp_nxt[SMP_B] = PINS_RELEASED;
            smp_nxt[SMP_C] = PINS_RELEASED;
          end
          if (det_e) begin
            ctl_nxt.det  = 1'b0;
            ctl_nxt.kind = cls_kind;
            ctl_nxt.mt   = cls_mt;
            ctl_nxt.step = cls_mt ? 4'd0 : 4'd1;
          end else begin
            res.valid     = 1'b1;
            res.x         = rx;
            res.y         = ry;
            res.btn       = rbtn;
            res.changed   = ctl.first || (rep != ctl.prev);
            ctl_nxt.prev  = rep;
            ctl_nxt.first = 1'b0;
            ctl_nxt.step  = '0;
          end
        end else begin
          ctl_nxt.step = {1'b0, h} + 4'd2;
        end
      end else begin
        ctl_nxt.tick = tick_e + 16'd1;
      end
    end
    res.kind = ctl_nxt.kind;
    res.mt   = ctl_nxt.mt;
  end

endmodule

// File: hdl/six_button_pad_reader_core.sv
// Six-button pad reader. Each input word is one tick of the time base and
// carries the pad pins; each tick gives exactly one output word with the
// select level, busy flag and, on the tick that ends a poll, the report.
// The block takes one word per clock while the output is not stalled, and
// passes it through an input register, one pass of tick logic, and an output
// register. While the output word is stalled the input register takes one
// more word, then the input stalls until the output moves. Write phase_ticks
// only while no word is in flight.
module six_button_pad_reader_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [5:0]  in_pad_pins,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_select_level,
  output logic        out_busy_res,
  output logic        out_report_valid,
  output logic [7:0]  out_stick_x,
  output logic [7:0]  out_stick_y,
  output logic [7:0]  out_button_byte,
  output logic        out_report_changed,
  output logic [1:0]  out_pad_kind,
  output logic        out_multitap_found,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import sbpr_pkg::*;

  logic        s1_valid_r;
  logic [1:0]  s1_op_r;
  logic [5:0]  s1_pins_r;
  logic        out_valid_r;
  res_t        res_r;
  res_t        res_nxt;
  ctl_t        ctl_r;
  ctl_t        ctl_nxt;
  sample_arr_t smp_r;
  sample_arr_t smp_nxt;
  logic [15:0] phase_ticks_r;
  logic        advance;

  assign advance   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign cfg_ready = 1'b1;

  sbpr_step u_step (
    .ctl         (ctl_r),
    .smp         (smp_r),
    .phase_ticks (phase_ticks_r),
    .operation   (s1_op_r),
    .pad_pins    (s1_pins_r),
    .ctl_nxt     (ctl_nxt),
    .smp_nxt     (smp_nxt),
    .res         (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      phase_ticks_r <= PHASE_TICKS_RST;
      ctl_r         <= '{step: '0, tick: '0, kind: KIND_THREE, prev: '0,
                         first: 1'b1, det: 1'b0, mt: 1'b0};
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        ctl_r       <= ctl_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        phase_ticks_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_op_r   <= in_operation;
      s1_pins_r <= in_pad_pins;
    end
    if (advance) begin
      res_r <= res_nxt;
      smp_r <= smp_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_select_level   = res_r.sel;
  assign out_busy_res       = res_r.busy;
  assign out_report_valid   = res_r.valid;
  assign out_stick_x        = res_r.x;
  assign out_stick_y        = res_r.y;
  assign out_button_byte    = res_r.btn;
  assign out_report_changed = res_r.changed;
  assign out_pad_kind       = res_r.kind;
  assign out_multitap_found = res_r.mt;

endmodule

// File: hdl/sbpr_checker.sv
module sbpr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_select_level,
  input logic       out_busy_res,
  input logic       out_report_valid,
  input logic [7:0] out_stick_x,
  input logic [7:0] out_stick_y,
  input logic       out_report_changed
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_report_valid)
      && $stable(out_stick_x) && $stable(out_busy_res))
    else $error("stalled output word changed");

  a_report_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_report_valid |-> out_busy_res)
    else $error("report outside a sequence");

  a_idle_select: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_busy_res |-> out_select_level && !out_report_valid)
    else $error("select low while idle");

  a_changed_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_report_changed |-> out_report_valid)
    else $error("changed flag without report");

  a_axis_levels: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_report_valid |->
      (out_stick_x == 8'd0 || out_stick_x == 8'd128 || out_stick_x == 8'd255)
      && (out_stick_y == 8'd0 || out_stick_y == 8'd128 || out_stick_y == 8'd255))
    else $error("axis off its three levels");

endmodule

bind six_button_pad_reader_core sbpr_checker u_sbpr_checker (.*);

// File: dv/tb_six_button_pad_reader_core.sv
module tb_six_button_pad_reader_core;
  timeunit 1ns;
  timeprecision 1ps;

  import sbpr_pkg::*;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int RandomItems   = 640;
  localparam int WatchdogLimit = 2000;

  typedef enum logic [2:0] {
    PAD_NOISE,
    PAD_RELEASED,
    PAD_PRESSED,
    PAD_SIMPLE,
    PAD_THREE,
    PAD_SIX,
    PAD_MULTITAP,
    PAD_START_HELD
  } pad_mode_e;

  logic        clk;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_stall;
  logic [1:0]  in_operation = OP_TICK;
  logic [5:0]  in_pad_pins  = '0;
  logic        out_valid;
  logic        out_stall    = 1'b0;
  logic        out_select_level;
  logic        out_busy_res;
  logic        out_report_valid;
  logic [7:0]  out_stick_x;
  logic [7:0]  out_stick_y;
  logic [7:0]  out_button_byte;
  logic        out_report_changed;
  logic [1:0]  out_pad_kind;
  logic        out_multitap_found;
  logic        cfg_valid    = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data     = '0;

  logic [3:0]  rd_step        = '0;
  int          rd_tick        = 0;
  sample_arr_t rd_samples     = '0;
  logic [1:0]  rd_kind        = KIND_THREE;
  logic [23:0] rd_prev        = '0;
  logic        rd_first       = 1'b1;
  logic        rd_detect      = 1'b0;
  logic        rd_multitap    = 1'b0;
  logic [15:0] rd_phase_ticks = PHASE_TICKS_RST;

  res_t      reader_words_q[$];
  pad_mode_e pad_mode   = PAD_NOISE;
  int        n_sent     = 0;
  int        n_words    = 0;
  int        errors     = 0;
  int        idle_count = 0;
  int        rx_hold    = 0;
  int        rx_gap     = 0;
  bit        tx_quiet   = 1'b0;
  bit        rx_quiet   = 1'b0;

  six_button_pad_reader_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_pad_pins       (in_pad_pins),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_select_level  (out_select_level),
    .out_busy_res      (out_busy_res),
    .out_report_valid  (out_report_valid),
    .out_stick_x       (out_stick_x),
    .out_stick_y       (out_stick_y),
    .out_button_byte   (out_button_byte),
    .out_report_changed(out_report_changed),
    .out_pad_kind      (out_pad_kind),
    .out_multitap_found(out_multitap_found),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Pins as a pad of the chosen sort would show them in the half phase this tick lands in.
  function automatic logic [5:0] pad_word(input logic [1:0] op);
    logic [5:0] p;
    logic [2:0] h;
    p = 6'($urandom_range(0, 63));
    if (rd_step == 0 && op != OP_POLL && op != OP_DETECT) return p;
    h = (rd_step == 0) ? HP_A : 3'(rd_step - 4'd1);
    case (pad_mode)
      PAD_RELEASED: p = PINS_RELEASED;
      PAD_PRESSED:  p = '0;
      PAD_SIMPLE: begin
        if (h == HP_A) p[3:0] = 4'($urandom_range(4, 14));
      end
      PAD_MULTITAP: begin
        if (h == HP_A) p[3:0] = NIB_MULTITAP;
      end
      PAD_THREE, PAD_SIX, PAD_START_HELD: begin
        if (h == HP_A) p[3:0] = NIB_IDLE;
        if (h == HP_B) begin
          p[3:0] = NIB_MULTITAP;
          if (pad_mode == PAD_THREE) p[5] = 1'b1;
          if (pad_mode == PAD_START_HELD) p[5] = 1'b0;
        end
        if ((h == HP_D || h == HP_E) && pad_mode != PAD_SIX) p[3:0] = NIB_MULTITAP;
      end
      default: ;
    endcase
    return p;
  endfunction

  task automatic advance_reader(input logic [1:0] op, input logic [5:0] pins);
    res_t        r;
    logic [2:0]  h;
    int          lim;
    logic        single;
    logic [5:0]  dn0, dn1, dn2;
    logic [7:0]  x, y, btn;
    logic [23:0] rep;
    r = '0;
    r.sel = 1'b1;
    if (rd_step == 0 && (op == OP_POLL || op == OP_DETECT)) begin
      rd_step = 4'd1;
      rd_tick = 0;
      rd_detect = (op == OP_DETECT);
    end
    if (rd_step != 0) begin
      h = 3'(rd_step - 4'd1);
      lim = (rd_phase_ticks == 0) ? 1 : int'(rd_phase_ticks);
      r.busy = 1'b1;
      r.sel = ~h[0];
      if (rd_tick + 1 >= lim) begin
        single = !rd_detect && rd_kind < KIND_THREE;
        case (h)
          HP_A: rd_samples[SMP_A] = pins;
          HP_B: rd_samples[SMP_B] = pins;
          HP_D: rd_samples[SMP_D] = pins;
          HP_E: rd_samples[SMP_E] = pins;
          HP_C: rd_samples[SMP_C] = pins;
          default: ;
        endcase
        rd_tick = 0;
        if ((single && h == HP_A) || h == HP_LAST) begin
          if (single) begin
            rd_samples[SMP_B] = PINS_RELEASED;
            rd_samples[SMP_C] = PINS_RELEASED;
          end
          if (rd_detect) begin
            rd_detect = 1'b0;
            rd_kind = KIND_TWO;
            rd_multitap = (rd_samples[SMP_A][3:0] == NIB_MULTITAP);
            if (!rd_multitap) begin
              if (rd_samples[SMP_A][3:0] == NIB_IDLE && rd_samples[SMP_B][3:0] == NIB_MULTITAP)
                rd_kind = (rd_samples[SMP_D][3:0] != NIB_MULTITAP ||
                           rd_samples[SMP_E][3:0] != NIB_MULTITAP) ? KIND_SIX : KIND_THREE;
              if (!rd_samples[SMP_B][5]) rd_kind = KIND_SIX;
            end
            rd_step = rd_multitap ? 4'd0 : 4'd1;
          end else begin
            dn0 = ~rd_samples[SMP_A];
            dn1 = ~rd_samples[SMP_B];
            dn2 = ~rd_samples[SMP_C];
            x = AXIS_MID;
            y = AXIS_MID;
            btn = '0;
            if (dn0[0]) y = AXIS_MIN;
            if (dn0[1]) y = AXIS_MAX;
            if (dn0[2]) x = AXIS_MIN;
            if (dn0[3]) x = AXIS_MAX;
            if (rd_kind >= KIND_THREE) begin
              btn[0] = dn1[4];
              btn[1] = dn0[4];
              btn[2] = dn0[5];
              btn[3] = dn1[5];
              if (rd_kind == KIND_SIX) begin
                btn[4] = dn2[2];
                btn[5] = dn2[1];
                btn[6] = dn2[0];
                btn[7] = dn2[3];
              end
            end else begin
              btn[0] = dn0[4];
              btn[1] = dn0[5];
            end
            rep = {btn, y, x};
            r.valid = 1'b1;
            r.x = x;
            r.y = y;
            r.btn = btn;
            r.changed = rd_first || (rep != rd_prev);
            rd_first = 1'b0;
            rd_prev = rep;
            rd_step = '0;
          end
        end else begin
          rd_step = {1'b0, h} + 4'd2;
        end
      end else begin
        rd_tick++;
      end
    end
    r.kind = rd_kind;
    r.mt = rd_multitap;
    reader_words_q.push_back(r);
  endtask

  task automatic send_word(input logic [1:0] op, input logic [5:0] pins);
    in_valid <= 1'b1;
    in_operation <= op;
    in_pad_pins <= pins;
    do @(posedge clk); while (in_stall);
    advance_reader(op, pins);
    n_sent++;
  endtask

  task automatic idle_sender();
    int n;
    n = tx_quiet ? 0 : gap_len();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (reader_words_q.size() != 0);
  endtask

  task automatic write_phase_ticks(input logic [15:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    rd_phase_ticks = value;
  endtask

  // Start an operation, then keep ticking until the reader is idle again.
  task automatic run_sequence(input logic [1:0] op, input pad_mode_e mode);
    logic [1:0] filler;
    pad_mode = mode;
    send_word(op, pad_word(op));
    while (rd_step != 0) begin
      idle_sender();
      filler = 2'($urandom_range(0, 3));
      send_word(filler, pad_word(filler));
    end
  endtask

  task automatic flag_mismatch(input string field, input logic [7:0] got, input logic [7:0] want);
    $display("word %0d: %s got 0x%0h expected 0x%0h", n_words, field, got, want);
    errors++;
  endtask

  task automatic test_idle_ticks();
    send_word(OP_TICK, 6'h00);
    send_word(OP_SPARE, 6'h3f);
    idle_sender();
    send_word(OP_TICK, 6'h3f);
    send_word(OP_SPARE, 6'h00);
  endtask

  task automatic test_poll_at_reset();
    run_sequence(OP_POLL, PAD_THREE);
    run_sequence(OP_POLL, PAD_RELEASED);
    run_sequence(OP_POLL, PAD_RELEASED);
  endtask

  task automatic test_detect_kinds();
    write_phase_ticks(16'd0);
    run_sequence(OP_DETECT, PAD_RELEASED);
    run_sequence(OP_DETECT, PAD_PRESSED);
    run_sequence(OP_DETECT, PAD_MULTITAP);
    run_sequence(OP_DETECT, PAD_THREE);
    run_sequence(OP_DETECT, PAD_SIX);
    run_sequence(OP_DETECT, PAD_START_HELD);
    run_sequence(OP_DETECT, PAD_SIMPLE);
  endtask

  task automatic test_single_phase_poll();
    write_phase_ticks(16'd1);
    run_sequence(OP_DETECT, PAD_MULTITAP);
    run_sequence(OP_POLL, PAD_NOISE);
    run_sequence(OP_POLL, PAD_PRESSED);
    write_phase_ticks(16'd2);
    run_sequence(OP_DETECT, PAD_SIMPLE);
    run_sequence(OP_POLL, PAD_RELEASED);
  endtask

  task automatic test_backpressure();
    write_phase_ticks(16'd1);
    tx_quiet = 1'b1;
    rx_hold = 400;
    repeat (4) run_sequence(OP_DETECT, pad_mode_e'($urandom_range(0, 7)));
    tx_quiet = 1'b0;
    wait_drained();
    run_sequence(OP_POLL, PAD_SIX);
  endtask

  task automatic test_phase_extremes();
    write_phase_ticks(16'd1);
    run_sequence(OP_DETECT, PAD_MULTITAP);
    write_phase_ticks(16'd100);
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    run_sequence(OP_POLL, PAD_NOISE);
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    write_phase_ticks(16'd1);
    run_sequence(OP_DETECT, PAD_SIX);
  endtask

  task automatic test_random();
    int first;
    int pick;
    logic [1:0] op;
    first = n_sent;
    while (n_sent - first < RandomItems) begin
      tx_quiet = ($urandom_range(0, 9) == 0);
      rx_quiet = ($urandom_range(0, 9) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        pick = $urandom_range(0, 99);
        if (pick < 5) write_phase_ticks(16'd0);
        else if (pick < 70) write_phase_ticks(16'($urandom_range(1, 2)));
        else write_phase_ticks(16'($urandom_range(3, 8)));
      end else if (pick < 25) begin
        repeat ($urandom_range(1, 4)) begin
          idle_sender();
          op = $urandom_range(0, 1) ? OP_SPARE : OP_TICK;
          send_word(op, pad_word(op));
        end
      end else begin
        idle_sender();
        run_sequence((pick < 75) ? OP_DETECT : OP_POLL, pad_mode_e'($urandom_range(0, 7)));
      end
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rx_hold > 0) begin
      out_stall <= 1'b1;
      rx_hold--;
    end else if (rx_quiet) begin
      out_stall <= 1'b0;
    end else if (rx_gap > 0) begin
      out_stall <= 1'b1;
      rx_gap--;
    end else begin
      out_stall <= 1'b0;
      rx_gap = gap_len();
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (reader_words_q.size() == 0) begin
        flag_mismatch("unexpected word", 8'h0, 8'h0);
      end else begin
        want = reader_words_q.pop_front();
        if (out_select_level !== want.sel)
          flag_mismatch("select_level", 8'(out_select_level), 8'(want.sel));
        if (out_busy_res !== want.busy)
          flag_mismatch("busy_res", 8'(out_busy_res), 8'(want.busy));
        if (out_report_valid !== want.valid)
          flag_mismatch("report_valid", 8'(out_report_valid), 8'(want.valid));
        if (out_stick_x !== want.x) flag_mismatch("stick_x", out_stick_x, want.x);
        if (out_stick_y !== want.y) flag_mismatch("stick_y", out_stick_y, want.y);
        if (out_button_byte !== want.btn)
          flag_mismatch("button_byte", out_button_byte, want.btn);
        if (out_report_changed !== want.changed)
          flag_mismatch("report_changed", 8'(out_report_changed), 8'(want.changed));
        if (out_pad_kind !== want.kind)
          flag_mismatch("pad_kind", 8'(out_pad_kind), 8'(want.kind));
        if (out_multitap_found !== want.mt)
          flag_mismatch("multitap_found", 8'(out_multitap_found), 8'(want.mt));
      end
      n_words++;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_count = 0;
    else
      idle_count++;
    if (idle_count >= WatchdogLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_ticks();
    test_poll_at_reset();
    test_detect_kinds();
    test_single_phase_poll();
    test_backpressure();
    test_phase_extremes();
    test_random();
    wait_drained();
    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
